[hw/rtl/tdbl_pkg.sv]
// Shared types and constants for the tree distance block.
// Used by the front end, the command queue, the back end and the top level.
package tdbl_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 10;
    localparam int NODE_W          = 10;
    localparam int DIST_W          = 11;
    localparam int Q_DEPTH         = 2;

    localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              in_range;
    } op_t;

endpackage

[hw/rtl/tree_distance_binary_lifting.sv]
// Top level of the tree distance block: front end, command queue and back end.
// Depends on tdbl_pkg, tdbl_front, tdbl_queue and tdbl_back.
//
// The block holds a rooted tree (root node 1) and answers path-length queries by binary
// lifting. A distance query steps through every lift level on the way up to equal depth,
// with one read of the jump table per set bit of the depth difference, and then, unless the
// nodes meet at equal depth, makes one paired read per level on the way up to the common
// ancestor. A query is rejected when the tables are not built, when a node is out of range
// or when a node is unreached. A clear, and the pass that follows reset, sweep the parent
// and reach memories over all MAX_NODES entries, during which no transaction is executed. A
// build clears the reach memory and sets up the root, then runs marking passes (at most
// one pass per tree level plus one) and then a pass over the nodes for each lift level
// above the first. Up to two commands are queued while the back end works.
module tree_distance_binary_lifting
    import tdbl_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [NODE_W-1:0] node_a,
    input  logic [NODE_W-1:0] node_b,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DIST_W-1:0] distance,
    output logic              valid_res
);

    logic q_full;
    logic q_push;
    op_t  q_data;
    logic q_pop;
    logic head_valid;
    op_t  head_data;

    tdbl_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .node_a   (node_a),
        .node_b   (node_b),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    tdbl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    tdbl_back #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .distance   (distance),
        .valid_res  (valid_res)
    );

endmodule

[hw/rtl/tdbl_front.sv]
// Front end: accepts input transactions, drops rejected edge loads and range-checks nodes.
// Depends on tdbl_pkg.
module tdbl_front
    import tdbl_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [NODE_W-1:0] node_a,
    input  logic [NODE_W-1:0] node_b,
    input  logic              q_full,
    output logic              q_push,
    output op_t               q_data
);

    logic a_ok;
    logic b_ok;
    logic drop;
    cmd_t op;

    assign op   = cmd_t'(cmd);
    assign a_ok = 32'(node_a) < 32'(MAX_NODES);
    assign b_ok = 32'(node_b) < 32'(MAX_NODES);
    assign drop = (op == CMD_LOAD) && (!a_ok || !b_ok || node_a == '0 || node_b == '0
                  || node_b == ROOT_NODE || node_a == node_b);

    assign in_ready        = !q_full;
    assign q_push          = in_valid && !q_full && !drop;
    assign q_data.op       = op;
    assign q_data.node_a   = node_a;
    assign q_data.node_b   = node_b;
    assign q_data.in_range = a_ok && b_ok;

endmodule

[hw/rtl/tdbl_queue.sv]
// Short queue of classified commands between the front end and the back end.
// Depends on tdbl_pkg.
module tdbl_queue
    import tdbl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head_data
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    op_t                 slot_reg [Q_DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW:0]         count_reg;
    logic                do_pop;

    assign full       = count_reg == (PW+1)'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push && !full) - (PW+1)'(do_pop);
        end
    end

endmodule

[hw/rtl/tdbl_back.sv]
// Back end: tree memories, clearing sweeps, table build sequencer and distance query.
// Depends on tdbl_pkg.
module tdbl_back
    import tdbl_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  op_t               head_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DIST_W-1:0] distance,
    output logic              valid_res
);

    localparam int AW     = $clog2(MAX_NODES);
    localparam int JDEPTH = MAX_NODES * LIFT_LEVELS;
    localparam int JAW    = $clog2(JDEPTH);
    localparam int LW     = $clog2(LIFT_LEVELS);

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_BR_CLR, ST_ROOT, ST_MK_RD, ST_MK_CHK, ST_MK_PAR,
        ST_JP_RD, ST_JP_CHK, ST_JP_WR, ST_Q_RA, ST_Q_RB, ST_L1, ST_L1_W,
        ST_CMP, ST_L2, ST_L2_W, ST_FIN, ST_RES
    } state_t;

    logic [NODE_W-1:0] parent_mem [MAX_NODES];
    logic              reach_mem  [MAX_NODES];
    logic [NODE_W-1:0] depth_mem  [MAX_NODES];
    logic [NODE_W-1:0] jump_mem   [JDEPTH];

    logic              p_we, r_we, r_wd, d_we, j_we;
    logic [AW-1:0]     p_wa, p_ra, r_wa, r_ra, d_wa, d_ra;
    logic [NODE_W-1:0] p_wd, d_wd, j_wd;
    logic [JAW-1:0]    j_wa, j_ra0, j_ra1;
    logic [NODE_W-1:0] p_rd, d_rd, j_rd0, j_rd1;
    logic              r_rd;

    state_t            state_reg, state_next;
    logic [AW-1:0]     v_reg, v_next;
    logic [LW-1:0]     k_reg, k_next;
    logic [AW:0]       pass_reg, pass_next;
    logic              grew_reg, grew_next;
    logic              built_reg, built_next;
    logic [NODE_W-1:0] u_reg, u_next;
    logic [NODE_W-1:0] w_reg, w_next;
    logic [NODE_W-1:0] da_reg, da_next;
    logic [NODE_W-1:0] diff_reg, diff_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              ok_reg, ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] distance_reg, distance_next;
    logic              valid_res_reg, valid_res_next;

    logic [31:0]       diff_sh;
    logic              last_v;
    logic              last_k;

    function automatic logic [JAW-1:0] jaddr(input logic [AW-1:0] n, input logic [LW-1:0] lv);
        return JAW'(n) * JAW'(LIFT_LEVELS) + JAW'(lv);
    endfunction

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_wa] <= p_wd;
        end
        p_rd <= parent_mem[p_ra];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            reach_mem[r_wa] <= r_wd;
        end
        r_rd <= reach_mem[r_ra];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            depth_mem[d_wa] <= d_wd;
        end
        d_rd <= depth_mem[d_ra];
    end

    always_ff @(posedge clk)
    begin
        if (j_we)
        begin
            jump_mem[j_wa] <= j_wd;
        end
        j_rd0 <= jump_mem[j_ra0];
        j_rd1 <= jump_mem[j_ra1];
    end

    assign diff_sh   = 32'(diff_reg) >> k_reg;
    assign last_v    = v_reg == AW'(MAX_NODES-1);
    assign last_k    = k_reg == LW'(LIFT_LEVELS-1);
    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign valid_res = valid_res_reg;

    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        pass_next      = pass_reg;
        grew_next      = grew_reg;
        built_next     = built_reg;
        u_next         = u_reg;
        w_next         = w_reg;
        da_next        = da_reg;
        diff_next      = diff_reg;
        dist_next      = dist_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        distance_next  = distance_reg;
        valid_res_next = valid_res_reg;
        pop   = 1'b0;
        p_we  = 1'b0;
        p_wa  = '0;
        p_wd  = '0;
        p_ra  = '0;
        r_we  = 1'b0;
        r_wa  = '0;
        r_wd  = 1'b0;
        r_ra  = '0;
        d_we  = 1'b0;
        d_wa  = '0;
        d_wd  = '0;
        d_ra  = '0;
        j_we  = 1'b0;
        j_wa  = '0;
        j_wd  = '0;
        j_ra0 = '0;
        j_ra1 = '0;

        unique case (state_reg)
            ST_CLR:
            begin
                p_we = 1'b1;
                p_wa = v_reg;
                r_we = 1'b1;
                r_wa = v_reg;
                built_next = 1'b0;
                if (last_v)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop    = 1'b1;
                    v_next = '0;
                    unique case (head_data.op)
                        CMD_CLEAR:
                        begin
                            state_next = ST_CLR;
                        end
                        CMD_LOAD:
                        begin
                            p_we       = 1'b1;
                            p_wa       = AW'(head_data.node_b);
                            p_wd       = head_data.node_a;
                            built_next = 1'b0;
                        end
                        CMD_BUILD:
                        begin
                            state_next = ST_BR_CLR;
                        end
                        CMD_QUERY:
                        begin
                            u_next = head_data.node_a;
                            w_next = head_data.node_b;
                            if (!built_reg || !head_data.in_range)
                            begin
                                ok_next    = 1'b0;
                                dist_next  = '0;
                                state_next = ST_RES;
                            end
                            else
                            begin
                                r_ra       = AW'(head_data.node_a);
                                d_ra       = AW'(head_data.node_a);
                                state_next = ST_Q_RA;
                            end
                        end
                    endcase
                end
            end
            ST_BR_CLR:
            begin
                r_we = 1'b1;
                r_wa = v_reg;
                if (last_v)
                begin
                    k_next     = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                r_we = 1'b1;
                r_wa = AW'(ROOT_NODE);
                r_wd = 1'b1;
                d_we = 1'b1;
                d_wa = AW'(ROOT_NODE);
                j_we = 1'b1;
                j_wa = jaddr(AW'(ROOT_NODE), k_reg);
                j_wd = ROOT_NODE;
                if (last_k)
                begin
                    v_next     = AW'(2);
                    pass_next  = '0;
                    grew_next  = 1'b0;
                    state_next = ST_MK_RD;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_MK_RD:
            begin
                p_ra       = v_reg;
                r_ra       = v_reg;
                state_next = ST_MK_CHK;
            end
            ST_MK_CHK, ST_MK_PAR:
            begin
                if (state_reg == ST_MK_CHK && !r_rd && p_rd != '0)
                begin
                    u_next     = p_rd;
                    r_ra       = AW'(p_rd);
                    d_ra       = AW'(p_rd);
                    state_next = ST_MK_PAR;
                end
                else
                begin
                    if (state_reg == ST_MK_PAR && r_rd)
                    begin
                        r_we      = 1'b1;
                        r_wa      = v_reg;
                        r_wd      = 1'b1;
                        d_we      = 1'b1;
                        d_wa      = v_reg;
                        d_wd      = d_rd + 1'b1;
                        j_we      = 1'b1;
                        j_wa      = jaddr(v_reg, '0);
                        j_wd      = u_reg;
                        grew_next = 1'b1;
                    end
                    state_next = ST_MK_RD;
                    if (last_v)
                    begin
                        pass_next = pass_reg + 1'b1;
                        v_next    = AW'(2);
                        grew_next = 1'b0;
                        if (!((grew_reg || (state_reg == ST_MK_PAR && r_rd))
                              && 32'(pass_reg) + 32'd1 < 32'(MAX_NODES)))
                        begin
                            k_next     = LW'(1);
                            state_next = ST_JP_RD;
                        end
                    end
                    else
                    begin
                        v_next = v_reg + 1'b1;
                    end
                end
            end
            ST_JP_RD:
            begin
                r_ra       = v_reg;
                j_ra0      = jaddr(v_reg, k_reg - 1'b1);
                state_next = ST_JP_CHK;
            end
            ST_JP_CHK, ST_JP_WR:
            begin
                if (state_reg == ST_JP_CHK && r_rd)
                begin
                    j_ra0      = jaddr(AW'(j_rd0), k_reg - 1'b1);
                    state_next = ST_JP_WR;
                end
                else
                begin
                    if (state_reg == ST_JP_WR)
                    begin
                        j_we = 1'b1;
                        j_wa = jaddr(v_reg, k_reg);
                        j_wd = j_rd0;
                    end
                    state_next = ST_JP_RD;
                    if (last_v)
                    begin
                        v_next = AW'(2);
                        if (last_k)
                        begin
                            built_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        v_next = v_reg + 1'b1;
                    end
                end
            end
            ST_Q_RA:
            begin
                ok_next    = r_rd;
                da_next    = d_rd;
                r_ra       = AW'(w_reg);
                d_ra       = AW'(w_reg);
                state_next = ST_Q_RB;
            end
            ST_Q_RB:
            begin
                dist_next = '0;
                k_next    = LW'(LIFT_LEVELS-1);
                if (!(ok_reg && r_rd))
                begin
                    ok_next    = 1'b0;
                    state_next = ST_RES;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = ST_L1;
                    if (da_reg < d_rd)
                    begin
                        u_next    = w_reg;
                        w_next    = u_reg;
                        diff_next = d_rd - da_reg;
                    end
                    else
                    begin
                        diff_next = da_reg - d_rd;
                    end
                end
            end
            ST_L1, ST_L1_W:
            begin
                if (state_reg == ST_L1 && diff_sh[0])
                begin
                    j_ra0      = jaddr(AW'(u_reg), k_reg);
                    state_next = ST_L1_W;
                end
                else
                begin
                    if (state_reg == ST_L1_W)
                    begin
                        u_next    = j_rd0;
                        dist_next = dist_reg + DIST_W'(32'd1 << k_reg);
                    end
                    if (k_reg == '0)
                    begin
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = ST_L1;
                    end
                end
            end
            ST_CMP:
            begin
                k_next = LW'(LIFT_LEVELS-1);
                if (u_reg == w_reg)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    state_next = ST_L2;
                end
            end
            ST_L2:
            begin
                j_ra0      = jaddr(AW'(u_reg), k_reg);
                j_ra1      = jaddr(AW'(w_reg), k_reg);
                state_next = ST_L2_W;
            end
            ST_L2_W:
            begin
                if (j_rd0 != j_rd1)
                begin
                    u_next    = j_rd0;
                    w_next    = j_rd1;
                    dist_next = dist_reg + DIST_W'(32'd2 << k_reg);
                end
                if (k_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = ST_L2;
                end
            end
            ST_FIN:
            begin
                dist_next  = dist_reg + DIST_W'(2);
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = ok_reg ? dist_reg : '0;
                    valid_res_next = ok_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            v_reg         <= '0;
            k_reg         <= '0;
            pass_reg      <= '0;
            grew_reg      <= 1'b0;
            built_reg     <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            v_reg         <= v_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            grew_reg      <= grew_next;
            built_reg     <= built_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg         <= u_next;
        w_reg         <= w_next;
        da_reg        <= da_next;
        diff_reg      <= diff_next;
        dist_reg      <= dist_next;
        distance_reg  <= distance_next;
        valid_res_reg <= valid_res_next;
    end

endmodule
